FILE: hw/rtl/csv_response_field_splitter_defines.svh
// assertion macros for the csv response field splitter
// expects clk and rst in the scope of the including module
`ifndef CSV_RESPONSE_FIELD_SPLITTER_DEFINES_SVH
`define CSV_RESPONSE_FIELD_SPLITTER_DEFINES_SVH

// condition must never hold outside reset
`define CSVFS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CSVFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CSVFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/csvfs_pkg.sv
// types, codes and character constants for the csv response field splitter
// no dependencies
`timescale 1ns / 1ps

package csvfs_pkg;

  // characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;

  // result kinds
  localparam logic [1:0] KIND_PREFIX = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PARSE     = 3'd1;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd2;
  localparam logic [2:0] ERR_EMPTY_TAIL = 3'd3;
  localparam logic [2:0] ERR_PREFIX    = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_PARSE_MODE  = 2'd0;
  localparam logic [1:0] REG_MAX_FIELDS  = 2'd1;
  localparam logic [1:0] REG_EXP_PREFIX  = 2'd2;
  localparam logic [1:0] REG_EXP_PFX_LEN = 2'd3;

  localparam logic [1:0] MODE_PLAIN = 2'd0;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_PREFIX = 2'd1,
    PH_TAIL   = 2'd2,
    PH_FIELDS = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [4:0] field_index;
    logic [7:0] field_offset;
    logic [7:0] field_length;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_CR) || (b == CH_FF) || (b == CH_VT);
  endfunction

  function automatic out_item_t make_item(input logic [1:0] kind, input logic [4:0] idx,
                                          input logic [7:0] off, input logic [7:0] len,
                                          input logic [2:0] st, input logic lst);
    out_item_t r;
    r.item_kind    = kind;
    r.field_index  = idx;
    r.field_offset = off;
    r.field_length = len;
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

endpackage

FILE: hw/rtl/csv_response_field_splitter.sv
// csv response field splitter: top level, single module
// depends on csvfs_pkg and csv_response_field_splitter_defines.svh
`timescale 1ns / 1ps

// Splits one response line, one byte per transaction, into comma separated
// fields with leading and trailing whitespace trimmed, and reports each field
// (and in query modes the prefix before the first comma) as an offset and a
// length, followed by one status transaction that closes the line. Each byte
// passes an input register, then a single pass of parse logic that writes up
// to three results into a three-slot result register; the results leave one
// per cycle in order while result_ready is high. A byte is taken every cycle
// as long as each byte gives at most one result and result_ready is high; a
// byte that gives more results holds the input until all but the last have
// left, since the result slots drain at one transaction per cycle.
// Configuration is written through the cfg channel, which is always ready,
// and must only change while no line is in flight.
module csv_response_field_splitter #(
  parameter int MAX_LINE     = 256,
  parameter int MAX_FIELDS   = 16,
  parameter int PREFIX_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte stream
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  csvfs_pkg::in_item_t  byte_data,
  // result stream
  output logic                 result_valid,
  input  logic                 result_ready,
  output csvfs_pkg::out_item_t result_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  import csvfs_pkg::*;

  `include "csv_response_field_splitter_defines.svh"

  // position counters must hold MAX_LINE itself
  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam int FC_W  = $clog2(MAX_FIELDS + 1);
  localparam int CAP_W = (FC_W > 5) ? FC_W : 5;
  localparam int PFX_W = 8 * PREFIX_BYTES;

  // configuration registers
  logic [1:0]  parse_mode;
  logic [4:0]  max_fields;
  logic [63:0] expected_prefix;
  logic [3:0]  expected_prefix_length;

  // input register
  logic     in_q_valid;
  in_item_t in_q;

  // line state
  logic [POS_W-1:0] byte_position,       byte_position_next;
  logic [POS_W-1:0] field_start,         field_start_next;
  logic [POS_W-1:0] first_text_position, first_text_position_next;
  logic [POS_W-1:0] text_end_position,   text_end_position_next;
  logic             segment_has_text,    segment_has_text_next;
  logic [FC_W-1:0]  fields_seen,         fields_seen_next;
  phase_t           line_phase,          line_phase_next;
  logic [2:0]       error_code,          error_code_next;
  logic [PFX_W-1:0] prefix_bytes,        prefix_bytes_next;

  // result slots: process result, end-of-line span, status
  out_item_t  slot      [3];
  out_item_t  slot_next [3];
  logic [2:0] slot_valid, slot_valid_next;

  logic             advance;
  logic             bundle_free;
  logic             pop;
  logic [CAP_W-1:0] field_cap;
  logic [CAP_W-1:0] max_fields_ext;
  logic [POS_W-1:0] exp_len;
  logic             field_step;
  logic             ws;
  logic [7:0]       b;

  // prefix compare: length and the bytes inside that length
  function automatic logic prefix_bad(input logic [POS_W-1:0] len,
                                      input logic [PFX_W-1:0] got,
                                      input logic [63:0] want,
                                      input logic [POS_W-1:0] want_len);
    logic bad;
    bad = (len != want_len);
    for (int k = 0; k < PREFIX_BYTES; k++) begin
      if ((POS_W'(k) < len) && (got[8*k +: 8] != want[8*k +: 8])) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode             <= MODE_PLAIN;
      max_fields             <= 5'd16;
      expected_prefix        <= '0;
      expected_prefix_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PARSE_MODE:  parse_mode             <= cfg_data[1:0];
        REG_MAX_FIELDS:  max_fields             <= cfg_data[4:0];
        REG_EXP_PREFIX:  expected_prefix        <= cfg_data;
        REG_EXP_PFX_LEN: expected_prefix_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the build limit as the limit
  assign max_fields_ext = CAP_W'(max_fields);
  assign field_cap = (max_fields_ext == '0) ? CAP_W'(1) :
                     ((max_fields_ext > CAP_W'(MAX_FIELDS)) ? CAP_W'(MAX_FIELDS)
                                                             : max_fields_ext);
  assign exp_len = (expected_prefix_length > 4'(PREFIX_BYTES)) ? POS_W'(PREFIX_BYTES)
                                                               : POS_W'(expected_prefix_length);

  // slots can be reloaded once none is left, or at most one result is left and it leaves now
  assign pop         = result_valid && result_ready;
  assign bundle_free = (slot_valid == 3'b000) ||
                       (pop && ((slot_valid & (slot_valid - 3'b001)) == 3'b000));
  assign advance     = in_q_valid && bundle_free;
  assign byte_ready  = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_q <= byte_data;
    end
  end

  assign b  = in_q.data_byte;
  assign ws = is_ws(in_q.data_byte);

  // one pass over the byte: field parse first, then end-of-line handling
  always_comb begin
    byte_position_next       = byte_position;
    field_start_next         = field_start;
    first_text_position_next = first_text_position;
    text_end_position_next   = text_end_position;
    segment_has_text_next    = segment_has_text;
    fields_seen_next         = fields_seen;
    line_phase_next          = line_phase;
    error_code_next          = error_code;
    prefix_bytes_next        = prefix_bytes;
    slot_valid_next          = 3'b000;
    field_step               = 1'b0;
    for (int s = 0; s < 3; s++) begin
      slot_next[s] = '0;
    end

    if (error_code_next == ERR_NONE) begin
      if (byte_position < POS_W'(MAX_LINE)) begin
        case (line_phase)
          PH_BEFORE: begin
            if (!ws) begin
              if (parse_mode != MODE_PLAIN) begin
                if (b != CH_QUERY) begin
                  error_code_next = ERR_PARSE;
                end else begin
                  line_phase_next          = PH_PREFIX;
                  first_text_position_next = byte_position;
                  text_end_position_next   = byte_position + POS_W'(1);
                  prefix_bytes_next        = PFX_W'(b);
                end
              end else begin
                line_phase_next = PH_FIELDS;
                field_step      = 1'b1;
              end
            end
          end
          PH_PREFIX: begin
            if (b == CH_COMMA) begin
              slot_next[0] = make_item(KIND_PREFIX, 5'd0, 8'(first_text_position),
                                       8'(POS_W'(text_end_position - first_text_position)),
                                       ERR_NONE, 1'b0);
              slot_valid_next[0] = 1'b1;
              if (parse_mode[1] &&
                  prefix_bad(POS_W'(text_end_position - first_text_position),
                             prefix_bytes, expected_prefix, exp_len)) begin
                error_code_next = ERR_PREFIX;
              end
              line_phase_next  = PH_TAIL;
              field_start_next = byte_position + POS_W'(1);
            end else begin
              if (!ws) begin
                text_end_position_next = byte_position + POS_W'(1);
              end
              // byte lane write, only the first PREFIX_BYTES bytes are kept
              for (int k = 0; k < PREFIX_BYTES; k++) begin
                if (POS_W'(byte_position - first_text_position) == POS_W'(k)) begin
                  prefix_bytes_next[8*k +: 8] = b;
                end
              end
            end
          end
          PH_TAIL: begin
            if (!ws) begin
              line_phase_next = PH_FIELDS;
              field_step      = 1'b1;
            end
          end
          default: field_step = 1'b1;
        endcase

        if (field_step) begin
          if (b == CH_COMMA) begin
            if (CAP_W'(fields_seen_next) >= field_cap) begin
              error_code_next = ERR_TOO_MANY;
            end else begin
              slot_next[0] = segment_has_text_next ?
                make_item(KIND_FIELD, 5'(fields_seen_next), 8'(first_text_position_next),
                          8'(POS_W'(text_end_position_next - first_text_position_next)),
                          ERR_NONE, 1'b0) :
                make_item(KIND_FIELD, 5'(fields_seen_next), 8'(byte_position), 8'd0,
                          ERR_NONE, 1'b0);
              slot_valid_next[0]    = 1'b1;
              fields_seen_next      = fields_seen_next + FC_W'(1);
              segment_has_text_next = 1'b0;
            end
            field_start_next = byte_position + POS_W'(1);
          end else if (!ws) begin
            if (!segment_has_text_next) begin
              first_text_position_next = byte_position;
              segment_has_text_next    = 1'b1;
            end
            text_end_position_next = byte_position + POS_W'(1);
          end
        end
      end else begin
        error_code_next = ERR_TOO_LONG;
      end
    end

    if (byte_position < POS_W'(MAX_LINE)) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    if (in_q.last_byte) begin
      if (error_code_next == ERR_NONE) begin
        case (line_phase_next)
          PH_BEFORE: error_code_next = ERR_PARSE;
          PH_PREFIX: begin
            slot_next[1] = make_item(KIND_PREFIX, 5'd0, 8'(first_text_position_next),
                           8'(POS_W'(text_end_position_next - first_text_position_next)),
                           ERR_NONE, 1'b0);
            slot_valid_next[1] = 1'b1;
            if (parse_mode[1] &&
                prefix_bad(POS_W'(text_end_position_next - first_text_position_next),
                           prefix_bytes_next, expected_prefix, exp_len)) begin
              error_code_next = ERR_PREFIX;
            end
          end
          PH_TAIL: error_code_next = ERR_EMPTY_TAIL;
          default: begin
            // the line end closes the last field
            if (CAP_W'(fields_seen_next) >= field_cap) begin
              error_code_next = ERR_TOO_MANY;
            end else begin
              slot_next[1] = segment_has_text_next ?
                make_item(KIND_FIELD, 5'(fields_seen_next), 8'(first_text_position_next),
                          8'(POS_W'(text_end_position_next - first_text_position_next)),
                          ERR_NONE, 1'b0) :
                make_item(KIND_FIELD, 5'(fields_seen_next), 8'(field_start_next), 8'd0,
                          ERR_NONE, 1'b0);
              slot_valid_next[1] = 1'b1;
              fields_seen_next   = fields_seen_next + FC_W'(1);
            end
          end
        endcase
      end
      slot_next[2] = make_item(KIND_STATUS, 5'(fields_seen_next), 8'd0, 8'd0,
                               error_code_next, 1'b1);
      slot_valid_next[2] = 1'b1;

      // line state back to its reset values
      byte_position_next       = '0;
      field_start_next         = '0;
      first_text_position_next = '0;
      text_end_position_next   = '0;
      segment_has_text_next    = 1'b0;
      fields_seen_next         = '0;
      line_phase_next          = PH_BEFORE;
      error_code_next          = ERR_NONE;
      prefix_bytes_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      field_start         <= '0;
      first_text_position <= '0;
      text_end_position   <= '0;
      segment_has_text    <= 1'b0;
      fields_seen         <= '0;
      line_phase          <= PH_BEFORE;
      error_code          <= ERR_NONE;
      prefix_bytes        <= '0;
    end else if (advance) begin
      byte_position       <= byte_position_next;
      field_start         <= field_start_next;
      first_text_position <= first_text_position_next;
      text_end_position   <= text_end_position_next;
      segment_has_text    <= segment_has_text_next;
      fields_seen         <= fields_seen_next;
      line_phase          <= line_phase_next;
      error_code          <= error_code_next;
      prefix_bytes        <= prefix_bytes_next;
    end
  end

  // result slots: reload on advance, otherwise retire the lowest valid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 3'b000;
    end else if (advance) begin
      slot_valid <= slot_valid_next;
    end else if (pop) begin
      slot_valid <= slot_valid & (slot_valid - 3'b001);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < 3; s++) begin
        slot[s] <= slot_next[s];
      end
    end
  end

  assign result_valid = |slot_valid;
  assign result_data  = slot_valid[0] ? slot[0] :
                        (slot_valid[1] ? slot[1] : slot[2]);

  // status sits only in the last slot and goes out after every span
  `CSVFS_ASSERT_SAME(a_status_goes_last, result_valid && result_data.last, slot_valid == 3'b100, "status transaction not last")
  `CSVFS_ASSERT_NEVER(a_pos_in_range, byte_position > POS_W'(MAX_LINE), "byte position beyond line limit")
  `CSVFS_ASSERT_NEVER(a_fields_in_range, fields_seen > FC_W'(MAX_FIELDS), "field count beyond limit")
  `CSVFS_ASSERT_NEXT(a_line_cleared, advance && in_q.last_byte, (byte_position == '0) && (line_phase == PH_BEFORE) && (error_code == ERR_NONE), "line state not cleared after line end")
  `CSVFS_ASSERT_NEXT(a_error_sticky, (error_code != ERR_NONE) && !(advance && in_q.last_byte), error_code == $past(error_code), "error changed within a line")

endmodule

FILE: bench/tb_csv_response_field_splitter.sv
// self-checking bench for the csv response field splitter: directed lines, then random lines
// predicts every result transaction from its own model of the splitter
// depends on csvfs_pkg and the csv_response_field_splitter rtl
`timescale 1ns / 1ps

module tb_csv_response_field_splitter;
  import csvfs_pkg::*;

  localparam int LINE_LIMIT   = 256;
  localparam int FIELD_LIMIT  = 16;
  localparam int PFX_LIMIT    = 8;
  localparam int DRAIN_CYCLES = 6;     // settling time after the last expected result
  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
  localparam int RANDOM_BLOCKS = 8;
  localparam int BLOCK_BYTES  = 8;     // lines are sent until a block reaches this many bytes

  // parse modes
  localparam logic [1:0] MODE_QUERY     = 2'd1;
  localparam logic [1:0] MODE_CHECK     = 2'd2;
  localparam logic [1:0] MODE_CHECK_ALT = 2'd3;   // behaves as prefix check

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        byte_valid   = 1'b0;
  logic        byte_ready;
  in_item_t    byte_data    = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result_data;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = REG_PARSE_MODE;
  logic [63:0] cfg_data     = '0;

  csv_response_field_splitter #(
    .MAX_LINE    (LINE_LIMIT),
    .MAX_FIELDS  (FIELD_LIMIT),
    .PREFIX_BYTES(PFX_LIMIT)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_data   (byte_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // splitter model: register copies and per-line state
  // ---------------------------------------------------------------------------
  logic [1:0]  mode_cfg    = MODE_PLAIN;
  logic [4:0]  maxf_cfg    = 5'd16;
  logic [63:0] pfx_cfg     = '0;
  logic [3:0]  pfx_len_cfg = '0;

  int unsigned pos_q       = 0;
  int unsigned seg_start_q = 0;
  int unsigned txt_first_q = 0;
  int unsigned txt_end_q   = 0;
  int unsigned nfields_q   = 0;
  bit          has_text_q  = 1'b0;
  phase_t      phase_q     = PH_BEFORE;
  logic [2:0]  err_q       = ERR_NONE;
  logic [63:0] pfx_acc_q   = '0;

  logic [2:0]  last_status = ERR_NONE;   // status of the most recently predicted line
  out_item_t   span_results[$];          // expected result transactions, oldest first
  int          mismatches = 0;

  function automatic bit is_blank(input logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void queue_result(input logic [1:0] kind, input int unsigned idx,
                                       input int unsigned off, input int unsigned len,
                                       input logic [2:0] st, input logic lst);
    out_item_t r;
    r.item_kind    = kind;
    r.field_index  = idx[4:0];
    r.field_offset = off[7:0];
    r.field_length = len[7:0];
    r.status       = st;
    r.last         = lst;
    span_results.push_back(r);
  endfunction

  function automatic void clear_line();
    pos_q = 0; seg_start_q = 0; txt_first_q = 0; txt_end_q = 0;
    nfields_q = 0; has_text_q = 1'b0; phase_q = PH_BEFORE;
    err_q = ERR_NONE; pfx_acc_q = '0;
  endfunction

  // zero counts as one, anything over the build limit is clipped
  function automatic int unsigned field_limit();
    if (maxf_cfg == 0) return 1;
    if (maxf_cfg > FIELD_LIMIT) return FIELD_LIMIT;
    return maxf_cfg;
  endfunction

  function automatic bit prefix_differs();
    int unsigned n, want_len;
    logic [63:0] mask;
    n = txt_end_q - txt_first_q;
    want_len = (pfx_len_cfg > PFX_LIMIT) ? PFX_LIMIT : pfx_len_cfg;
    if (n != want_len) return 1'b1;
    mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    return ((pfx_acc_q ^ pfx_cfg) & mask) != '0;
  endfunction

  function automatic void emit_prefix();
    queue_result(KIND_PREFIX, 0, txt_first_q, txt_end_q - txt_first_q, ERR_NONE, 1'b0);
    // bit 1 of the mode turns the comparison on
    if (mode_cfg[1] && prefix_differs()) err_q = ERR_PREFIX;
  endfunction

  function automatic void close_field(input int unsigned empty_off);
    if (nfields_q >= field_limit()) begin
      err_q = ERR_TOO_MANY;
      return;
    end
    if (has_text_q)
      queue_result(KIND_FIELD, nfields_q, txt_first_q, txt_end_q - txt_first_q, ERR_NONE, 1'b0);
    else
      queue_result(KIND_FIELD, nfields_q, empty_off, 0, ERR_NONE, 1'b0);
    nfields_q++;
    has_text_q = 1'b0;
  endfunction

  function automatic void field_byte(input logic [7:0] b, input int unsigned p);
    if (b == CH_COMMA) begin
      close_field(p);
      seg_start_q = p + 1;
    end else if (!is_blank(b)) begin
      if (!has_text_q) begin
        txt_first_q = p;
        has_text_q = 1'b1;
      end
      txt_end_q = p + 1;
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b, input int unsigned p);
    case (phase_q)
      PH_BEFORE: begin
        if (is_blank(b)) return;
        if (mode_cfg != MODE_PLAIN) begin
          // query modes insist on a question mark first
          if (b != CH_QUERY) begin
            err_q = ERR_PARSE;
            return;
          end
          phase_q = PH_PREFIX;
          txt_first_q = p;
          txt_end_q = p + 1;
          pfx_acc_q = 64'(b);
        end else begin
          phase_q = PH_FIELDS;
          field_byte(b, p);
        end
      end
      PH_PREFIX: begin
        if (b == CH_COMMA) begin
          emit_prefix();
          phase_q = PH_TAIL;
          seg_start_q = p + 1;
        end else begin
          if (!is_blank(b)) txt_end_q = p + 1;
          // only the first eight prefix bytes, blanks included, are kept
          if (p - txt_first_q < PFX_LIMIT) pfx_acc_q[8 * (p - txt_first_q) +: 8] = b;
        end
      end
      PH_TAIL: begin
        if (!is_blank(b)) begin
          phase_q = PH_FIELDS;
          field_byte(b, p);
        end
      end
      default: field_byte(b, p);
    endcase
  endfunction

  // one accepted byte: queue whatever result transactions it causes
  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    if (err_q == ERR_NONE) begin
      if (pos_q < LINE_LIMIT) take_byte(b, pos_q);
      else err_q = ERR_TOO_LONG;
    end
    if (pos_q < LINE_LIMIT) pos_q++;
    if (fin) begin
      if (err_q == ERR_NONE) begin
        case (phase_q)
          PH_BEFORE: err_q = ERR_PARSE;        // nothing but blanks
          PH_PREFIX: emit_prefix();
          PH_TAIL:   err_q = ERR_EMPTY_TAIL;   // prefix comma, then only blanks
          default:   close_field(seg_start_q);
        endcase
      end
      queue_result(KIND_STATUS, nfields_q, 0, 0, err_q, 1'b1);
      last_status = err_q;
      clear_line();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pattern, long hold-off and checking
  // ---------------------------------------------------------------------------
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_start = 1'b0;   // toggled by the stimulus to ask for a hold-off
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;

  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen    <= hold_start;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // values are sampled before this edge's updates land, so the handshake is race free
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (span_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = span_results.pop_front();
        check_field("item_kind", result_data.item_kind, want.item_kind);
        check_field("field_index", result_data.field_index, want.field_index);
        check_field("field_offset", result_data.field_offset, want.field_offset);
        check_field("field_length", result_data.field_length, want.field_length);
        check_field("status", result_data.status, want.status);
        check_field("last", result_data.last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte side and configuration writes
  // ---------------------------------------------------------------------------
  logic [7:0] line_bytes[$];   // line about to be sent
  logic [7:0] pfx_text[$];     // prefix that lines of the current block tend to use

  // offer one byte, idling first at random; the model sees it once accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    byte_valid          <= 1'b1;
    byte_data.data_byte <= b;
    byte_data.last_byte <= fin;
    do @(posedge clk); while (!byte_ready);
    predict_byte(b, fin);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  // wait for every expected transaction, then let the pipeline settle
  task automatic drain();
    byte_valid <= 1'b0;
    while (span_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all four registers, back to back, only once the block is idle
  task automatic set_config(input logic [1:0] mode, input logic [4:0] maxf,
                            input logic [63:0] pfx, input logic [3:0] plen);
    drain();
    cfg_valid <= 1'b1;
    write_reg(REG_PARSE_MODE, 64'(mode));
    write_reg(REG_MAX_FIELDS, 64'(maxf));
    write_reg(REG_EXP_PREFIX, pfx);
    write_reg(REG_EXP_PFX_LEN, 64'(plen));
    cfg_valid <= 1'b0;
    mode_cfg = mode;
    maxf_cfg = maxf;
    pfx_cfg = pfx;
    pfx_len_cfg = plen;
  endtask

  // ---------------------------------------------------------------------------
  // random line building
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] ws_byte();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_FF;
      default: return CH_VT;
    endcase
  endfunction

  // printable most of the time, any non-blank non-comma byte now and then
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(33, 126));
    end while (b == CH_COMMA || is_blank(b));
    return b;
  endfunction

  function automatic void add_blanks(input int unsigned most);
    repeat ($urandom_range(0, most)) line_bytes.push_back(ws_byte());
  endfunction

  function automatic void build_line();
    int unsigned pick, nf;
    line_bytes.delete();
    pick = $urandom_range(99);
    // raw noise
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    // blanks only
    if (pick < 12) begin
      repeat ($urandom_range(1, 5)) line_bytes.push_back(ws_byte());
      return;
    end
    if (mode_cfg != MODE_PLAIN) begin
      add_blanks(2);
      if (pick < 16) begin
        line_bytes.push_back(8'($urandom_range(65, 90)));   // no question mark
      end else if ($urandom_range(9) < 7) begin
        foreach (pfx_text[i]) line_bytes.push_back(pfx_text[i]);
      end else begin
        line_bytes.push_back(CH_QUERY);
        repeat ($urandom_range(0, 10)) line_bytes.push_back(text_byte());
      end
      add_blanks(2);
      if (pick < 22) return;   // prefix closed by the end of the line
      line_bytes.push_back(CH_COMMA);
      if (pick < 28) begin
        add_blanks(3);         // empty tail
        return;
      end
    end
    // well-formed field list, now and then longer than any limit
    nf = ($urandom_range(9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 5);
    for (int k = 0; k < nf; k++) begin
      if (k != 0) line_bytes.push_back(CH_COMMA);
      add_blanks(2);
      repeat ($urandom_range(0, 5)) line_bytes.push_back(text_byte());
      add_blanks(2);
    end
    if (line_bytes.size() == 0) line_bytes.push_back(ws_byte());
  endfunction

  // ---------------------------------------------------------------------------
  // directed lines: expected status typed in where it is obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  mode;
    logic [4:0]  maxf;
    logic [63:0] pfx;
    logic [3:0]  pfx_len;
    int          pad;      // filler bytes sent ahead of the text
    string       text;
    bit          typed;
    logic [2:0]  want;
  } directed_row_t;

  directed_row_t directed_rows [15] = '{
    '{MODE_PLAIN,     5'd16, 64'h0,      4'd0,  0,   "a,b",         1'b1, ERR_NONE},
    '{MODE_PLAIN,     5'd16, 64'h0,      4'd0,  0,   " \t\n",       1'b1, ERR_PARSE},
    '{MODE_PLAIN,     5'd1,  64'h0,      4'd0,  0,   "x,y",         1'b1, ERR_TOO_MANY},
    '{MODE_QUERY,     5'd16, 64'h0,      4'd0,  0,   " abc",        1'b1, ERR_PARSE},
    '{MODE_QUERY,     5'd16, 64'h0,      4'd0,  0,   "?id, \t",     1'b1, ERR_EMPTY_TAIL},
    '{MODE_CHECK,     5'd16, 64'h4B4F3F, 4'd3,  0,   "?OK,1, 2 ",   1'b1, ERR_NONE},
    '{MODE_CHECK,     5'd16, 64'h4B4F3F, 4'd3,  0,   "?NO,1",       1'b1, ERR_PREFIX},
    '{MODE_PLAIN,     5'd16, 64'h0,      4'd0,  0,   ",,\013",      1'b0, ERR_NONE},
    '{MODE_PLAIN,     5'd31, 64'h0,      4'd0,  0,   " a b ,\015c\014, ", 1'b0, ERR_NONE},
    '{MODE_CHECK_ALT, 5'd0,  '1,         4'd15, 0,   "\t?x ,a",     1'b1, ERR_PREFIX},
    '{MODE_PLAIN,     5'd0,  64'h0,      4'd0,  0,   "p,q",         1'b1, ERR_TOO_MANY},
    '{MODE_PLAIN,     5'd31, 64'h0,      4'd0,  0,
      "0,1,2,3,4,5,6,7,8,9,a,b,c,d,e,f,g",                          1'b1, ERR_TOO_MANY},
    '{MODE_QUERY,     5'd16, 64'h0,      4'd0,  0,   "?abcdefghij ,z", 1'b0, ERR_NONE},
    '{MODE_PLAIN,     5'd16, 64'h0,      4'd0,  260, "z",           1'b1, ERR_TOO_LONG},
    '{MODE_PLAIN,     5'd16, 64'h0,      4'd0,  0,   "\377\200\177\001", 1'b0, ERR_NONE}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          sent, tl;
    logic [1:0]  mode_v;
    logic [4:0]  maxf_v;
    logic [63:0] pfx_v;
    logic [3:0]  plen_v;
    bit          matched;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    foreach (directed_rows[r]) begin
      set_config(directed_rows[r].mode, directed_rows[r].maxf,
                 directed_rows[r].pfx, directed_rows[r].pfx_len);
      line_bytes.delete();
      repeat (directed_rows[r].pad) line_bytes.push_back(8'h7A);
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        line_bytes.push_back(directed_rows[r].text[i]);
      send_line();
      if (directed_rows[r].typed && last_status != directed_rows[r].want)
        report_mismatch($sformatf("row %0d: predicted status %0d, table gives %0d",
                                  r, last_status, directed_rows[r].want));
    end

    // random part: one register setting per block, idling pattern by block
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      matched = 1'b0;
      tl = $urandom_range(1, PFX_LIMIT);
      pfx_v = '0;
      plen_v = '0;
      case (blk)
        0: begin mode_v = MODE_PLAIN; maxf_v = 5'd16; end
        1: begin
          mode_v = MODE_QUERY; maxf_v = 5'd1;
          pfx_v = {$urandom, $urandom}; plen_v = 4'($urandom_range(15));
        end
        2: begin mode_v = MODE_CHECK; maxf_v = 5'($urandom_range(1, 16)); matched = 1'b1; end
        3: begin
          mode_v = MODE_CHECK_ALT; maxf_v = 5'd0; pfx_v = '1; plen_v = 4'd15; tl = PFX_LIMIT;
        end
        4: begin mode_v = MODE_PLAIN; maxf_v = 5'd31; pfx_v = '1; plen_v = 4'd8; end
        5: begin mode_v = MODE_CHECK; maxf_v = 5'd16; matched = 1'b1; tl = PFX_LIMIT; end
        6: begin mode_v = MODE_QUERY; maxf_v = 5'($urandom_range(31)); end
        default: begin mode_v = MODE_CHECK_ALT; maxf_v = 5'd16; matched = 1'b1; tl = 1; end
      endcase

      // prefix the lines of this block will mostly carry
      pfx_text.delete();
      pfx_text.push_back(CH_QUERY);
      repeat (tl - 1) pfx_text.push_back(text_byte());
      if (matched) begin
        foreach (pfx_text[i]) pfx_v[8 * i +: 8] = pfx_text[i];
        plen_v = 4'(tl);
      end
      set_config(mode_v, maxf_v, pfx_v, plen_v);

      case (blk % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      // sender runs flat out while the receiver holds off, so the input backs up
      if (blk == 0) hold_start <= ~hold_start;

      sent = 0;
      while (sent < BLOCK_BYTES) begin
        build_line();
        send_line();
        sent += line_bytes.size();
      end
    end

    drain();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // generous ceiling, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
